// ===== sv/uqsd_pkg.sv =====
// ----------------------------------------------------------------------------
// uqsd_pkg
// Shared types, character codes and helpers for the url query string decoder.
// ----------------------------------------------------------------------------
package uqsd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RES     = 4;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] HEX_NONE = 8'hFF;

   typedef enum logic [2:0] {
      KIND_PATH     = 3'd0,
      KIND_PATH_END = 3'd1,
      KIND_NAME     = 3'd2,
      KIND_VALUE    = 3'd3,
      KIND_PAIR_END = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_type;

   // results caused by one accepted word
   typedef struct packed {
      logic [2:0]             cnt;
      logic                   done;
      kind_type [MAX_RES-1:0] kind;
      logic [MAX_RES-1:0][7:0] data;
   } bundle_type;

   function automatic logic [7:0] hex_of(input logic [7:0] c);
      logic [7:0] r;
      begin
         r = HEX_NONE;
         if (c >= 8'h30 && c <= 8'h39) begin
            r = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            r = c - 8'h57;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            r = c - 8'h37;
         end
         return r;
      end
   endfunction

   function automatic bundle_type add_res(input bundle_type b, input kind_type k,
                                          input logic [7:0] d);
      bundle_type r;
      begin
         r = b;
         if (b.cnt < 3'(MAX_RES)) begin
            r.kind[b.cnt[1:0]] = k;
            r.data[b.cnt[1:0]] = d;
            r.cnt = b.cnt + 3'd1;
         end
         return r;
      end
   endfunction

endpackage

// ===== sv/uqsd_front.sv =====
// ----------------------------------------------------------------------------
// uqsd_front
// Parses each uri byte and turns it into a bundle of up to four results.
// ----------------------------------------------------------------------------
module uqsd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            uri_byte,
   input  logic                  final_byte,
   output logic                  push,
   output uqsd_pkg::bundle_type  bundle
);

   logic                  in_query_ff, in_query_in;
   logic                  pair_open_ff, pair_open_in;
   logic                  in_value_ff, in_value_in;
   uqsd_pkg::esc_type     esc_ff, esc_in;
   logic [7:0]            held_ff, held_in;
   uqsd_pkg::bundle_type  res;
   uqsd_pkg::kind_type    fk;
   logic [7:0]            h;
   logic [7:0]            hh;

   always_comb begin
      res          = '0;
      in_query_in  = in_query_ff;
      pair_open_in = pair_open_ff;
      in_value_in  = in_value_ff;
      esc_in       = esc_ff;
      held_in      = held_ff;
      h            = uqsd_pkg::hex_of(uri_byte);
      hh           = uqsd_pkg::hex_of(held_ff);
      fk           = in_value_ff ? uqsd_pkg::KIND_VALUE : uqsd_pkg::KIND_NAME;

      if (!in_query_ff) begin
         if (uri_byte == uqsd_pkg::CH_QM) begin
            res = uqsd_pkg::add_res(res, uqsd_pkg::KIND_PATH_END, 8'd0);
            in_query_in = 1'b1;
         end else begin
            res = uqsd_pkg::add_res(res, uqsd_pkg::KIND_PATH, uri_byte);
            if (final_byte) begin
               res = uqsd_pkg::add_res(res, uqsd_pkg::KIND_PATH_END, 8'd0);
            end
         end
      end else if (uri_byte == uqsd_pkg::CH_AMP) begin
         if (esc_ff == uqsd_pkg::ESC_PCT || esc_ff == uqsd_pkg::ESC_DIGIT) begin
            res = uqsd_pkg::add_res(res, fk, uqsd_pkg::CH_PCT);
         end
         if (esc_ff == uqsd_pkg::ESC_DIGIT) begin
            res = uqsd_pkg::add_res(res, fk, held_ff);
         end
         esc_in  = uqsd_pkg::ESC_NONE;
         held_in = 8'd0;
         res = uqsd_pkg::add_res(res, uqsd_pkg::KIND_PAIR_END, 8'd0);
         pair_open_in = 1'b0;
         in_value_in  = 1'b0;
      end else if (uri_byte == uqsd_pkg::CH_EQ && !in_value_ff) begin
         if (esc_ff == uqsd_pkg::ESC_PCT || esc_ff == uqsd_pkg::ESC_DIGIT) begin
            res = uqsd_pkg::add_res(res, fk, uqsd_pkg::CH_PCT);
         end
         if (esc_ff == uqsd_pkg::ESC_DIGIT) begin
            res = uqsd_pkg::add_res(res, fk, held_ff);
         end
         esc_in       = uqsd_pkg::ESC_NONE;
         held_in      = 8'd0;
         in_value_in  = 1'b1;
         pair_open_in = 1'b1;
      end else begin
         pair_open_in = 1'b1;
         if (esc_ff == uqsd_pkg::ESC_PCT && h != uqsd_pkg::HEX_NONE) begin
            held_in = uri_byte;
            esc_in  = uqsd_pkg::ESC_DIGIT;
         end else if (esc_ff == uqsd_pkg::ESC_DIGIT && h != uqsd_pkg::HEX_NONE) begin
            res     = uqsd_pkg::add_res(res, fk, {hh[3:0], h[3:0]});
            esc_in  = uqsd_pkg::ESC_NONE;
            held_in = 8'd0;
         end else begin
            // broken escape goes out raw, then the byte is handled anew
            if (esc_ff == uqsd_pkg::ESC_PCT || esc_ff == uqsd_pkg::ESC_DIGIT) begin
               res = uqsd_pkg::add_res(res, fk, uqsd_pkg::CH_PCT);
            end
            if (esc_ff == uqsd_pkg::ESC_DIGIT) begin
               res = uqsd_pkg::add_res(res, fk, held_ff);
            end
            esc_in  = uqsd_pkg::ESC_NONE;
            held_in = 8'd0;
            if (uri_byte == uqsd_pkg::CH_PCT) begin
               esc_in = uqsd_pkg::ESC_PCT;
            end else if (uri_byte == uqsd_pkg::CH_PLUS) begin
               res = uqsd_pkg::add_res(res, fk, uqsd_pkg::CH_SPACE);
            end else begin
               res = uqsd_pkg::add_res(res, fk, uri_byte);
            end
         end
      end

      if (final_byte) begin
         if (in_query_in && pair_open_in) begin
            fk = in_value_in ? uqsd_pkg::KIND_VALUE : uqsd_pkg::KIND_NAME;
            if (esc_in == uqsd_pkg::ESC_PCT || esc_in == uqsd_pkg::ESC_DIGIT) begin
               res = uqsd_pkg::add_res(res, fk, uqsd_pkg::CH_PCT);
            end
            if (esc_in == uqsd_pkg::ESC_DIGIT) begin
               res = uqsd_pkg::add_res(res, fk, held_in);
            end
            res = uqsd_pkg::add_res(res, uqsd_pkg::KIND_PAIR_END, 8'd0);
         end
         in_query_in  = 1'b0;
         pair_open_in = 1'b0;
         in_value_in  = 1'b0;
         esc_in       = uqsd_pkg::ESC_NONE;
         held_in      = 8'd0;
      end
      res.done = final_byte;
   end

   assign bundle = res;
   assign push   = accept && (res.cnt != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_query_ff  <= 1'b0;
         pair_open_ff <= 1'b0;
         in_value_ff  <= 1'b0;
         esc_ff       <= uqsd_pkg::ESC_NONE;
         held_ff      <= 8'd0;
      end else if (accept) begin
         in_query_ff  <= in_query_in;
         pair_open_ff <= pair_open_in;
         in_value_ff  <= in_value_in;
         esc_ff       <= esc_in;
         held_ff      <= held_in;
      end
   end

endmodule

// ===== sv/uqsd_queue.sv =====
// ----------------------------------------------------------------------------
// uqsd_queue
// Small first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module uqsd_queue #(
   parameter int Depth = uqsd_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  uqsd_pkg::bundle_type  wr_bundle,
   input  logic                  pop,
   output uqsd_pkg::bundle_type  rd_bundle,
   output logic                  empty,
   output logic                  full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   uqsd_pkg::bundle_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] level_ff, level_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + CntW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - CntW'(1);
      end
   end

   assign empty     = (level_ff == '0);
   assign full      = (level_ff == CntW'(Depth));
   assign rd_bundle = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== sv/uqsd_back.sv =====
// ----------------------------------------------------------------------------
// uqsd_back
// Walks through the head bundle and sends its results one word per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module uqsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  uqsd_pkg::bundle_type  q_bundle,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic [2:0]            rsp_tuser
);

   logic                valid_ff, valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic [7:0]          data_ff, data_in;
   logic                last_ff, last_in;
   uqsd_pkg::kind_type  kind_ff, kind_in;
   logic                load;
   logic                bundle_end;

   assign load       = !valid_ff || rsp_tready;
   assign bundle_end = ({1'b0, idx_ff} + 3'd1) == q_bundle.cnt;
   assign pop        = load && !q_empty && bundle_end;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      kind_in  = kind_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            kind_in = q_bundle.kind[idx_ff];
            data_in = q_bundle.data[idx_ff];
            // uri_done rides on the last result of the final byte
            last_in = bundle_end && q_bundle.done;
            idx_in  = bundle_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

endmodule

// ===== sv/url_query_string_decoder.sv =====
// ----------------------------------------------------------------------------
// url_query_string_decoder
// Splits a request uri into path bytes, query names and values, percent decoded.
// ----------------------------------------------------------------------------
// the results of a byte pass through the bundle queue and then the output register.
// a byte is accepted every cycle while the bundle queue has room.
// results leave one word per cycle from the output register while rsp_tready is
// high, so once the queue fills the input runs at the pace of the results (one to
// four for a byte that has any), and a byte with no result never enters the queue.
// reset clears the parse state, the queue and the output valid flag at once.
// ----------------------------------------------------------------------------
module url_query_string_decoder #(
   parameter int QueueDepth = uqsd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] uri_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data
   output logic       rsp_tlast,   // uri_done
   output logic [2:0] rsp_tuser    // [2:0] kind
);

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   uqsd_pkg::bundle_type wr_bundle;
   uqsd_pkg::bundle_type rd_bundle;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   uqsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .uri_byte   (req_tdata),
      .final_byte (req_tlast),
      .push       (push),
      .bundle     (wr_bundle)
   );

   uqsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_bundle (wr_bundle),
      .pop       (pop),
      .rd_bundle (rd_bundle),
      .empty     (q_empty),
      .full      (q_full)
   );

   uqsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_bundle   (rd_bundle),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("bundle pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("bundle popped from empty queue");

   a_bundle_count: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (rd_bundle.cnt != 3'd0 && rd_bundle.cnt <= 3'd4))
      else $error("queued bundle has bad result count");

   a_final_word: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |-> push)
      else $error("final byte produced no result");

endmodule

// ===== tb/url_query_string_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// url_query_string_decoder_tb
// Drives request uris byte by byte into the decoder: first a directed table of
// path, escape, flush and empty-pair cases, then random uris, most of them well
// formed with random content and the rest noise. Every result word is checked
// against table words or an in-bench model, with random stalls on both streams.
// ----------------------------------------------------------------------------
module url_query_string_decoder_tb;

   localparam int RANDOM_ITEMS = 290;
   localparam int CALM_ITEMS   = 60;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      uqsd_pkg::kind_type kind;
      logic [7:0]         data;
      logic               done;
   } decoded_word_type;

   typedef struct packed {
      logic [7:0]         uri_byte;
      logic               final_byte;
      logic [1:0]         n_typed;
      uqsd_pkg::kind_type k0;
      logic [7:0]         d0;
      uqsd_pkg::kind_type k1;
      logic [7:0]         d1;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [2:0] rsp_tuser;

   // decoder model state
   logic              mdl_in_query;
   logic              mdl_pair_open;
   logic              mdl_in_value;
   uqsd_pkg::esc_type mdl_esc;
   logic [7:0]        mdl_held;

   decoded_word_type step_words[$];
   decoded_word_type expected_words[$];
   stim_row_type     directed_rows[$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;
   bit calm           = 1'b0;

   url_query_string_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------
   function automatic void clear_model();
      mdl_in_query  = 1'b0;
      mdl_pair_open = 1'b0;
      mdl_in_value  = 1'b0;
      mdl_esc       = uqsd_pkg::ESC_NONE;
      mdl_held      = 8'h00;
   endfunction

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return c - "0";
      end else if (c >= "a" && c <= "f") begin
         return c - "a" + 8'd10;
      end else if (c >= "A" && c <= "F") begin
         return c - "A" + 8'd10;
      end
      return uqsd_pkg::HEX_NONE;
   endfunction

   function automatic uqsd_pkg::kind_type field_kind();
      return mdl_in_value ? uqsd_pkg::KIND_VALUE : uqsd_pkg::KIND_NAME;
   endfunction

   function automatic void emit_word(input uqsd_pkg::kind_type k, input logic [7:0] d);
      decoded_word_type w;
      w = '{kind: k, data: d, done: 1'b0};
      if (step_words.size() < uqsd_pkg::MAX_RES) begin
         step_words.insert(step_words.size(), w);
      end
   endfunction

   // a partial escape comes out raw in the field that holds it
   function automatic void flush_held();
      if (mdl_esc == uqsd_pkg::ESC_PCT) begin
         emit_word(field_kind(), uqsd_pkg::CH_PCT);
      end else if (mdl_esc == uqsd_pkg::ESC_DIGIT) begin
         emit_word(field_kind(), uqsd_pkg::CH_PCT);
         emit_word(field_kind(), mdl_held);
      end
      mdl_esc  = uqsd_pkg::ESC_NONE;
      mdl_held = 8'h00;
   endfunction

   function automatic void plain_byte(input logic [7:0] c);
      if (c == uqsd_pkg::CH_PCT) begin
         mdl_esc = uqsd_pkg::ESC_PCT;
      end else if (c == uqsd_pkg::CH_PLUS) begin
         emit_word(field_kind(), uqsd_pkg::CH_SPACE);
      end else begin
         emit_word(field_kind(), c);
      end
   endfunction

   function automatic void field_byte(input logic [7:0] c);
      logic [7:0] h;
      logic [7:0] hi;
      h  = hex_value(c);
      hi = hex_value(mdl_held);
      if (mdl_esc == uqsd_pkg::ESC_PCT && h != uqsd_pkg::HEX_NONE) begin
         mdl_held = c;
         mdl_esc  = uqsd_pkg::ESC_DIGIT;
      end else if (mdl_esc == uqsd_pkg::ESC_DIGIT && h != uqsd_pkg::HEX_NONE) begin
         emit_word(field_kind(), {hi[3:0], h[3:0]});
         mdl_esc  = uqsd_pkg::ESC_NONE;
         mdl_held = 8'h00;
      end else begin
         if (mdl_esc == uqsd_pkg::ESC_PCT || mdl_esc == uqsd_pkg::ESC_DIGIT) begin
            flush_held();
         end
         mdl_esc = uqsd_pkg::ESC_NONE;
         plain_byte(c);
      end
   endfunction

   // fills step_words with the results of one accepted byte
   function automatic void decode_byte(input logic [7:0] c, input logic fin);
      step_words.delete();
      if (!mdl_in_query) begin
         if (c == uqsd_pkg::CH_QM) begin
            emit_word(uqsd_pkg::KIND_PATH_END, 8'h00);
            mdl_in_query = 1'b1;
         end else begin
            emit_word(uqsd_pkg::KIND_PATH, c);
            if (fin) begin
               emit_word(uqsd_pkg::KIND_PATH_END, 8'h00);
            end
         end
      end else if (c == uqsd_pkg::CH_AMP) begin
         flush_held();
         emit_word(uqsd_pkg::KIND_PAIR_END, 8'h00);
         mdl_pair_open = 1'b0;
         mdl_in_value  = 1'b0;
      end else if (c == uqsd_pkg::CH_EQ && !mdl_in_value) begin
         flush_held();
         mdl_in_value  = 1'b1;
         mdl_pair_open = 1'b1;
      end else begin
         mdl_pair_open = 1'b1;
         field_byte(c);
      end
      if (fin) begin
         if (mdl_in_query && mdl_pair_open) begin
            flush_held();
            emit_word(uqsd_pkg::KIND_PAIR_END, 8'h00);
         end
         if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].done = 1'b1;
         end
         clear_model();
      end
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // called at a falling edge; returns at the rising edge that takes the word
   task automatic offer_byte(input logic [7:0] b, input logic fin);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, fin);
      items_sent++;
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      offer_byte(b, fin);
      foreach (step_words[i]) begin
         expected_words.insert(expected_words.size(), step_words[i]);
      end
      @(negedge clock);
      sender_gap();
   endtask

   // hold the request stream until every result has drained
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_field_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
      if (r < 50) return 8'(hex_value(8'h00) == uqsd_pkg::HEX_NONE ?
                            ($urandom_range(0, 2) == 0 ? "0" + $urandom_range(0, 9) :
                             ($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 5)) : 0);
      if (r < 60) return uqsd_pkg::CH_PLUS;
      if (r < 75) return uqsd_pkg::CH_PCT;
      if (r < 80) return uqsd_pkg::CH_EQ;
      if (r < 85) return uqsd_pkg::CH_QM;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] pick_path_byte();
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0) begin
         b = 8'($urandom_range(1, 255));
         if (b == uqsd_pkg::CH_QM) b = "/";
      end else begin
         b = $urandom_range(0, 4) == 0 ? "/" : 8'("a" + $urandom_range(0, 25));
      end
      return b;
   endfunction

   task automatic send_uri(input bit noisy);
      logic [7:0] uri[$];
      int         n_pairs;
      if (noisy) begin
         repeat ($urandom_range(1, 8)) begin
            uri.insert(uri.size(), $urandom_range(0, 2) == 0 ? pick_field_byte() :
                                   8'($urandom_range(1, 255)));
         end
      end else begin
         repeat ($urandom_range(0, 5)) uri.insert(uri.size(), pick_path_byte());
         if ($urandom_range(0, 99) < 85) begin
            uri.insert(uri.size(), uqsd_pkg::CH_QM);
            n_pairs = $urandom_range(0, 3);
            for (int p = 0; p < n_pairs; p++) begin
               if (p > 0) uri.insert(uri.size(), uqsd_pkg::CH_AMP);
               repeat ($urandom_range(0, 4)) uri.insert(uri.size(), pick_field_byte());
               if ($urandom_range(0, 9) < 7) begin
                  uri.insert(uri.size(), uqsd_pkg::CH_EQ);
                  repeat ($urandom_range(0, 5)) uri.insert(uri.size(), pick_field_byte());
               end
            end
            if ($urandom_range(0, 5) == 0) uri.insert(uri.size(), uqsd_pkg::CH_AMP);
         end
      end
      if (uri.size() == 0) uri.insert(0, "x");
      foreach (uri[i]) begin
         calm = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
         send_byte(uri[i], i == uri.size() - 1);
      end
   endtask

   function automatic stim_row_type row(input logic [7:0] b, input logic fin,
                                        input logic [1:0] n_typed = 2'd0,
                                        input uqsd_pkg::kind_type k0 = uqsd_pkg::KIND_PATH,
                                        input logic [7:0] d0 = 8'h00,
                                        input uqsd_pkg::kind_type k1 = uqsd_pkg::KIND_PATH,
                                        input logic [7:0] d1 = 8'h00);
      return '{uri_byte: b, final_byte: fin, n_typed: n_typed,
               k0: k0, d0: d0, k1: k1, d1: d1};
   endfunction

   initial begin
      decoded_word_type w;
      stim_row_type     r;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      clear_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_rows = {
         // raw path bytes at the extremes, then the query
         row("a",   1'b0, 2'd1, uqsd_pkg::KIND_PATH, "a"),
         row(8'hFF, 1'b0, 2'd1, uqsd_pkg::KIND_PATH, 8'hFF),
         row(8'h01, 1'b0, 2'd1, uqsd_pkg::KIND_PATH, 8'h01),
         row(uqsd_pkg::CH_QM, 1'b0, 2'd1, uqsd_pkg::KIND_PATH_END, 8'h00),
         // name: full escape, plus, held digit flushed at '='
         row(uqsd_pkg::CH_PCT,  1'b0),
         row("4",               1'b0),
         row("1",               1'b0),
         row(uqsd_pkg::CH_PLUS, 1'b0),
         row(uqsd_pkg::CH_PCT,  1'b0),
         row("a",               1'b0),
         row(uqsd_pkg::CH_EQ,   1'b0),
         // value: later '=' and '?' and a zero byte are ordinary
         row(uqsd_pkg::CH_EQ,   1'b0),
         row(uqsd_pkg::CH_QM,   1'b0),
         row(8'h00,             1'b0),
         // bad escape, then a held digit flushed at '&', then an empty pair
         row(uqsd_pkg::CH_PCT,  1'b0),
         row("g",               1'b0),
         row(uqsd_pkg::CH_PCT,  1'b0),
         row("B",               1'b0),
         row(uqsd_pkg::CH_AMP,  1'b0),
         row(uqsd_pkg::CH_AMP,  1'b0, 2'd1, uqsd_pkg::KIND_PAIR_END, 8'h00),
         // four words from one byte: flush, the byte, the closing pair end
         row(uqsd_pkg::CH_EQ,   1'b0),
         row(uqsd_pkg::CH_PCT,  1'b0),
         row("f",               1'b0),
         row("z",               1'b1),
         // one-byte uris, a trailing '&', a lone '%' at the end of a value
         row("x", 1'b1, 2'd2, uqsd_pkg::KIND_PATH, "x",
             uqsd_pkg::KIND_PATH_END, 8'h00),
         row(uqsd_pkg::CH_QM,  1'b1, 2'd1, uqsd_pkg::KIND_PATH_END, 8'h00),
         row(uqsd_pkg::CH_QM,  1'b0, 2'd1, uqsd_pkg::KIND_PATH_END, 8'h00),
         row(uqsd_pkg::CH_AMP, 1'b1, 2'd1, uqsd_pkg::KIND_PAIR_END, 8'h00),
         row(uqsd_pkg::CH_QM,  1'b0, 2'd1, uqsd_pkg::KIND_PATH_END, 8'h00),
         row(uqsd_pkg::CH_EQ,  1'b0),
         row(uqsd_pkg::CH_PCT, 1'b1)
      };

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         offer_byte(r.uri_byte, r.final_byte);
         if (r.n_typed == 2'd0) begin
            foreach (step_words[j]) begin
               expected_words.insert(expected_words.size(), step_words[j]);
            end
         end else begin
            w = '{kind: r.k0, data: r.d0, done: r.final_byte && r.n_typed == 2'd1};
            expected_words.insert(expected_words.size(), w);
            if (r.n_typed == 2'd2) begin
               w = '{kind: r.k1, data: r.d1, done: r.final_byte};
               expected_words.insert(expected_words.size(), w);
            end
         end
         @(negedge clock);
         sender_gap();
      end
      drain_results();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         send_uri($urandom_range(0, 4) == 0);
         if (!calm && $urandom_range(0, 11) == 0) drain_results();
      end
      drain_results();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      decoded_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no word, got kind %0d data %02h last %0b", $time,
                     rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.data ||
                rsp_tlast !== want.done) begin
               mismatch_count++;
               $display("%0t: expected kind %0d data %02h last %0b, %s %0d data %02h last %0b",
                        $time, want.kind, want.data, want.done, "got kind",
                        rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // stall watchdog: no word moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
